>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, held off during reset.
`define SSTG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, held off during reset.
`define SSTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/sstg_pkg.sv
// Types, constants and table-building functions for the stepped sine tone generator.
package sstg_pkg;

    // Field widths
    localparam int BTN_W    = 5;
    localparam int SAMPLE_W = 10;
    localparam int VOL_W    = 4;
    localparam int FREQ_W   = 12;

    // Button bit positions within a scan
    localparam int KEY_UP    = 0;
    localparam int KEY_DOWN  = 1;
    localparam int KEY_LEFT  = 2;
    localparam int KEY_RIGHT = 3;
    localparam int KEY_ENTER = 4;

    // Volume and tone limits
    localparam logic [VOL_W-1:0]  VOL_MAX    = 4'd9;
    localparam logic [VOL_W-1:0]  VOL_RESET  = 4'd5;
    localparam logic [FREQ_W-1:0] FREQ_MIN   = 12'd100;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = 12'd3000;
    localparam logic [FREQ_W-1:0] FREQ_STEP  = 12'd50;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 12'd600;

    // Tone settings are held as an index into the list of 50 Hz steps
    localparam int NSTEPS    = (3000 - 100) / 50 + 1;
    localparam int IDX_W     = $clog2(NSTEPS);
    localparam logic [IDX_W-1:0] IDX_RESET = IDX_W'((600 - 100) / 50);
    localparam logic [IDX_W-1:0] IDX_MAX   = IDX_W'(NSTEPS - 1);

    // Sine table scaling
    localparam logic [63:0] PEAK_VAL    = 64'd585;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Item kinds
    typedef enum logic {
        CMD_SCAN = 1'b0,
        CMD_TICK = 1'b1
    } sstg_cmd_t;

    // Settings after an item, handed from the control unit to the result stage
    typedef struct packed {
        logic [VOL_W-1:0]  volume;
        logic [FREQ_W-1:0] tone_hz;
        logic              stop;
    } sstg_status_t;

    // Quarter-wave sine in Q30 by a truncating Taylor series of degree 17.
    // Used only to build the constant table at elaboration.
    function automatic logic [63:0] quarter_sine(int table_bits, logic [63:0] r);
        logic [63:0]        qtr;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        qtr = 64'd1 << (table_bits - 2);
        if (r == 64'd0)
        begin
            return 64'd0;
        end
        if (r >= qtr)
        begin
            return ONE_Q30;
        end
        x    = (HALF_PI_Q30 * r) >> (table_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        if (sum > $signed(ONE_Q30))
        begin
            sum = $signed(ONE_Q30);
        end
        return $unsigned(sum);
    endfunction

    // One table entry: floor(floor((sin + 1) * 585) / 2) over a full period.
    function automatic logic [SAMPLE_W-1:0] sine_entry(int table_bits, int idx);
        logic [63:0] qtr;
        logic [63:0] i;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] v;
        qtr = 64'd1 << (table_bits - 2);
        i   = 64'(idx);
        q   = (i >> (table_bits - 2)) & 64'd3;
        r   = i & (qtr - 64'd1);
        case (q)
            64'd0:   v = ONE_Q30 + quarter_sine(table_bits, r);
            64'd1:   v = ONE_Q30 + quarter_sine(table_bits, qtr - r);
            64'd2:   v = ONE_Q30 - quarter_sine(table_bits, r);
            default: v = ONE_Q30 - quarter_sine(table_bits, qtr - r);
        endcase
        s = (v * PEAK_VAL) >> 30;
        s = s >> 1;
        return s[SAMPLE_W-1:0];
    endfunction

endpackage

>>> rtl/core/sstg_item_if.sv
// Request channel carrying button scans and sample ticks into the block.
interface sstg_item_if;
    import sstg_pkg::*;

    logic             valid;
    logic             ready;
    logic             command;
    logic [BTN_W-1:0] buttons;

    modport source (output valid, output command, output buttons, input ready);
    modport sink   (input valid, input command, input buttons, output ready);
endinterface

>>> rtl/core/sstg_result_if.sv
// Request channel carrying one result per item out of the block.
interface sstg_result_if;
    import sstg_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_valid;
    logic [VOL_W-1:0]    volume_level;
    logic [FREQ_W-1:0]   tone_hz;
    logic                stop_request;

    modport source (output valid, output sample, output sample_valid, output volume_level,
                    output tone_hz, output stop_request, input ready);
    modport sink   (input valid, input sample, input sample_valid, input volume_level,
                    input tone_hz, input stop_request, output ready);
endinterface

>>> rtl/core/sstg_sine_rom.sv
// Full-period sine lookup table with a registered read port.
module sstg_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [TABLE_BITS-1:0]         addr,
    output logic [sstg_pkg::SAMPLE_W-1:0] data
);
    import sstg_pkg::*;

    localparam int DEPTH = 1 << TABLE_BITS;

    typedef logic [SAMPLE_W-1:0] rom_array_t [DEPTH];

    function automatic rom_array_t build_rom();
        rom_array_t tab;
        for (int i = 0; i < DEPTH; i++)
        begin
            tab[i] = sine_entry(TABLE_BITS, i);
        end
        return tab;
    endfunction

    localparam rom_array_t ROM_DATA = build_rom();

    logic [SAMPLE_W-1:0] data_reg;

    // Registered read, held while the port is not enabled.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM_DATA[addr];
        end
    end

    assign data = data_reg;
endmodule

>>> rtl/core/sstg_phase.sv
// Phase accumulator and sine table lookup for the sample ticks.
module sstg_phase #(
    parameter int PHASE_BITS = 32,
    parameter int TABLE_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic                          tick_en,
    input  logic [PHASE_BITS-1:0]         phase_step,
    output logic [sstg_pkg::SAMPLE_W-1:0] sample
);
    import sstg_pkg::*;

    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] acc_next;

    // The sample is read at the phase before the step is added.
    assign acc_next = tick_en ? acc_reg + phase_step : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Top bits of the phase address the table.
    sstg_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (rd_en),
        .addr (acc_reg[PHASE_BITS-1 -: TABLE_BITS]),
        .data (sample)
    );
endmodule

>>> rtl/core/sstg_ctrl.sv
// Button edge detection, volume and tone settings, and the phase step for the tone.
module sstg_ctrl #(
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_RATE = 32000
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       scan_en,
    input  logic [sstg_pkg::BTN_W-1:0] buttons,
    output sstg_pkg::sstg_status_t     status,
    output logic [PHASE_BITS-1:0]      phase_step
);
    import sstg_pkg::*;

    typedef logic [PHASE_BITS-1:0] step_array_t [NSTEPS];

    // Phase step for every tone setting, rounded to nearest.
    function automatic step_array_t build_steps();
        step_array_t tab;
        logic [63:0] f;
        logic [63:0] q;
        for (int n = 0; n < NSTEPS; n++)
        begin
            f      = 64'(FREQ_MIN) + 64'(FREQ_STEP) * 64'(n);
            q      = ((f << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
            tab[n] = q[PHASE_BITS-1:0];
        end
        return tab;
    endfunction

    localparam step_array_t STEP_TABLE = build_steps();

    logic [BTN_W-1:0]      prev_reg;
    logic [BTN_W-1:0]      prev_next;
    logic [VOL_W-1:0]      vol_reg;
    logic [VOL_W-1:0]      vol_next;
    logic [FREQ_W-1:0]     freq_reg;
    logic [FREQ_W-1:0]     freq_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] step_next;

    logic [BTN_W-1:0]  pressed;
    logic [VOL_W-1:0]  vol_up;
    logic [VOL_W-1:0]  vol_calc;
    logic [FREQ_W-1:0] freq_left;
    logic [FREQ_W-1:0] freq_calc;
    logic [IDX_W-1:0]  idx_left;
    logic [IDX_W-1:0]  idx_calc;

    // Newly pressed buttons act in the order up, down, left, right.
    always_comb
    begin
        pressed = buttons & ~prev_reg;

        vol_up   = (pressed[KEY_UP] && (vol_reg < VOL_MAX)) ? vol_reg + VOL_W'(1) : vol_reg;
        vol_calc = (pressed[KEY_DOWN] && (vol_up != '0)) ? vol_up - VOL_W'(1) : vol_up;

        freq_left = freq_reg;
        idx_left  = idx_reg;
        if (pressed[KEY_LEFT] && (freq_reg > FREQ_MIN))
        begin
            freq_left = freq_reg - FREQ_STEP;
            idx_left  = idx_reg - IDX_W'(1);
        end

        freq_calc = freq_left;
        idx_calc  = idx_left;
        if (pressed[KEY_RIGHT] && (freq_left < FREQ_MAX) && (idx_left < IDX_MAX))
        begin
            freq_calc = freq_left + FREQ_STEP;
            idx_calc  = idx_left + IDX_W'(1);
        end
    end

    // Settings move only on an accepted button scan.
    always_comb
    begin
        prev_next = scan_en ? buttons : prev_reg;
        vol_next  = scan_en ? vol_calc : vol_reg;
        freq_next = scan_en ? freq_calc : freq_reg;
        idx_next  = scan_en ? idx_calc : idx_reg;
        step_next = scan_en ? STEP_TABLE[idx_calc] : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            vol_reg  <= VOL_RESET;
            freq_reg <= FREQ_RESET;
            idx_reg  <= IDX_RESET;
            step_reg <= STEP_TABLE[IDX_RESET];
        end
        else
        begin
            prev_reg <= prev_next;
            vol_reg  <= vol_next;
            freq_reg <= freq_next;
            idx_reg  <= idx_next;
            step_reg <= step_next;
        end
    end

    // Settings as they stand after this item.
    always_comb
    begin
        status.volume  = vol_next;
        status.tone_hz = freq_next;
        status.stop    = scan_en && pressed[KEY_ENTER];
    end

    assign phase_step = step_reg;
endmodule

>>> rtl/core/stepped_sine_tone_generator_unit.sv
// Top level of the stepped sine tone generator.
//
// The item channel takes one request per item: a button scan (command low)
// carrying raw button levels, or a sample tick (command high). The result
// channel gives exactly one request per item, in order: the sine sample and
// its valid flag on a tick, and after every item the volume, the tone in
// hertz and the one-scan stop flag raised by a fresh press of enter.
// An item is held in an input register, then the settings update, phase
// advance and table read run in one pass into the result register.
// A result is offered once its item has passed the input register and then
// the result register. Throughput: one item per cycle while results are
// taken; the sine table read and the phase add fit in the single pass, and
// the table is a registered read port.
// Reset clears the phase to zero, the tone to 600 Hz, the volume to 5 and
// the previous button scan to none; both stages come out empty.
// When the receiver stalls, the result is held and one further item is
// still taken into the input register before the item channel stalls.
module stepped_sine_tone_generator_unit #(
    parameter int PHASE_BITS  = 32,
    parameter int TABLE_BITS  = 10,
    parameter int SAMPLE_RATE = 32000
) (
    input  logic          clk,
    input  logic          rst_n,
    sstg_item_if.sink     item,
    sstg_result_if.source result
);
    import sstg_pkg::*;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    sstg_cmd_t        s1_command_reg;
    logic [BTN_W-1:0] s1_buttons_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_sample_valid_reg;
    logic [VOL_W-1:0]  out_volume_reg;
    logic [FREQ_W-1:0] out_tone_reg;
    logic              out_stop_reg;

    logic                  accept;
    logic                  advance;
    logic                  scan_en;
    logic                  tick_en;
    sstg_status_t          status;
    logic [PHASE_BITS-1:0] phase_step;
    logic [SAMPLE_W-1:0]   sample_q;

    // Handshake: the held item moves on when the result register is free or being taken.
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign accept     = item.valid && item.ready;
    assign scan_en    = advance && (s1_command_reg == CMD_SCAN);
    assign tick_en    = advance && (s1_command_reg == CMD_TICK);

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    // Control state of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_command_reg <= sstg_cmd_t'(item.command);
            s1_buttons_reg <= item.buttons;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sample_valid_reg <= (s1_command_reg == CMD_TICK);
            out_volume_reg       <= status.volume;
            out_tone_reg         <= status.tone_hz;
            out_stop_reg         <= status.stop;
        end
    end

    sstg_ctrl #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_en    (scan_en),
        .buttons    (s1_buttons_reg),
        .status     (status),
        .phase_step (phase_step)
    );

    sstg_phase #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (advance),
        .tick_en    (tick_en),
        .phase_step (phase_step),
        .sample     (sample_q)
    );

    // Result channel; a scan result carries a zero sample.
    assign result.valid        = out_valid_reg;
    assign result.sample       = out_sample_valid_reg ? sample_q : '0;
    assign result.sample_valid = out_sample_valid_reg;
    assign result.volume_level = out_volume_reg;
    assign result.tone_hz      = out_tone_reg;
    assign result.stop_request = out_stop_reg;
endmodule

>>> rtl/core/sstg_checker.sv
// Port-level checks on the result channel of the tone generator, bound to the top level.
`include "assert_macros.svh"

module sstg_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [sstg_pkg::SAMPLE_W-1:0] sample,
    input logic                          sample_valid,
    input logic [sstg_pkg::VOL_W-1:0]    volume_level,
    input logic [sstg_pkg::FREQ_W-1:0]   tone_hz,
    input logic                          stop_request
);
    import sstg_pkg::*;

    logic limits_ok;

    // Volume and tone both lie within their ranges.
    assign limits_ok = (volume_level <= VOL_MAX) && (tone_hz >= FREQ_MIN) &&
                       (tone_hz <= FREQ_MAX);

    // A stalled result stays offered.
    `SSTG_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)

    // A scan result carries no sample.
    `SSTG_ASSERT_SAME(a_scan_zero, out_valid && !sample_valid, sample == '0)

    // A tick never raises the stop flag.
    `SSTG_ASSERT_SAME(a_tick_no_stop, out_valid && sample_valid, !stop_request)

    // Settings stay within their limits.
    `SSTG_ASSERT_SAME(a_limits, out_valid, limits_ok)

    // Samples never exceed the peak of the table.
    `SSTG_ASSERT_SAME(a_sample_peak, out_valid && sample_valid, sample <= SAMPLE_W'(585))
endmodule

bind stepped_sine_tone_generator_unit sstg_checker u_sstg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .sample       (result.sample),
    .sample_valid (result.sample_valid),
    .volume_level (result.volume_level),
    .tone_hz      (result.tone_hz),
    .stop_request (result.stop_request)
);
